FILE: design/tppcs_pkg.sv
// Shared types, constants and lookup functions for the three-phase PWM compare shifter.
`default_nettype none
package tppcs_pkg;

    localparam int DUTY_FRACTION_BITS = 15;
    localparam int CMP_W              = 16;
    localparam int GAP_W              = 14;
    localparam int PROD_W             = 2 * CMP_W;
    localparam int SECTOR_W           = 3;

    typedef logic [CMP_W-1:0]    cmp_t;
    typedef logic [GAP_W-1:0]    gap_t;
    typedef logic [SECTOR_W-1:0] sector_t;

    // configuration register indexes
    typedef enum logic {
        REG_PERIOD  = 1'b0,
        REG_MIN_GAP = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_U = 2'd0,
        PH_V = 2'd1,
        PH_W = 2'd2
    } phase_t;

    localparam sector_t SECTOR_ZERO_LO = 3'd0;
    localparam sector_t SECTOR_ZERO_HI = 3'd7;

    typedef struct packed {
        cmp_t duty_u;
        cmp_t duty_v;
        cmp_t duty_w;
    } duty_t;

    typedef struct packed {
        cmp_t    rise_u;
        cmp_t    rise_v;
        cmp_t    rise_w;
        cmp_t    fall_u;
        cmp_t    fall_v;
        cmp_t    fall_w;
        sector_t sector;
    } result_t;

    // sector plus the phases holding min, medium and max duty
    typedef struct packed {
        sector_t sector;
        phase_t  mn;
        phase_t  md;
        phase_t  mx;
    } sect_entry_t;

    function automatic sect_entry_t sect_lookup(input logic [2:0] idx);
        sect_entry_t e;
        case (idx)
            3'd0:    e = '{sector: 3'd0, mn: PH_U, md: PH_V, mx: PH_W};
            3'd1:    e = '{sector: 3'd2, mn: PH_W, md: PH_U, mx: PH_V};
            3'd2:    e = '{sector: 3'd4, mn: PH_U, md: PH_V, mx: PH_W};
            3'd3:    e = '{sector: 3'd3, mn: PH_U, md: PH_W, mx: PH_V};
            3'd4:    e = '{sector: 3'd6, mn: PH_V, md: PH_W, mx: PH_U};
            3'd5:    e = '{sector: 3'd1, mn: PH_W, md: PH_V, mx: PH_U};
            3'd6:    e = '{sector: 3'd5, mn: PH_V, md: PH_U, mx: PH_W};
            default: e = '{sector: 3'd7, mn: PH_U, md: PH_V, mx: PH_W};
        endcase
        return e;
    endfunction

    // three-way select of a per-phase compare value
    function automatic cmp_t phase_pick(input cmp_t u, input cmp_t v, input cmp_t w,
                                        input phase_t p);
        cmp_t r;
        case (p)
            PH_U:    r = u;
            PH_V:    r = v;
            default: r = w;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/three_phase_pwm_compare_shift.sv
// Three-phase PWM compare generator with edge shifting for single-shunt sampling.
// done and result come out of the input, scale and shift registers in turn.
// Throughput: one beat per cycle; busy is held low.
// The receiver cannot stall: each result is shown for one cycle with done high.
// Reset: period returns to 2000, min_gap to 100, pipeline valid flags clear.
`default_nettype none
module three_phase_pwm_compare_shift
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tppcs_pkg::duty_t   duty,
    output logic                    done,
    output tppcs_pkg::result_t      result,
    input  wire logic               cfg_we,
    input  wire tppcs_pkg::cfg_reg_t cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import tppcs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cmp_t period_reg;
    gap_t min_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= CMP_W'(2000);
            min_gap_reg <= GAP_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data[CMP_W-1:0];
                REG_MIN_GAP: min_gap_reg <= cfg_data[GAP_W-1:0];
                default:     ;
            endcase
        end
    end

    // Every stage moves on each cycle, so the block never pushes back.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the duty beat
    // ------------------------------------------------------------------
    logic  v1_reg;
    duty_t duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            duty_reg <= duty;
    end

    // ------------------------------------------------------------------
    // Stage 2: scale duties to compare values, build the sector index
    // cmp = period - ((duty * period) >> frac), all mod 2^16
    // ------------------------------------------------------------------
    logic [2:0][CMP_W-1:0]  duty_arr;
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0][CMP_W-1:0]  cmp_next;
    logic [2:0]             idx;
    sect_entry_t            entry_next;

    always_comb
    begin
        duty_arr[0] = duty_reg.duty_u;
        duty_arr[1] = duty_reg.duty_v;
        duty_arr[2] = duty_reg.duty_w;
        for (int i = 0; i < 3; i++)
        begin
            prod[i]     = PROD_W'(duty_arr[i]) * PROD_W'(period_reg);
            cmp_next[i] = period_reg - prod[i][DUTY_FRACTION_BITS +: CMP_W];
        end
        idx[2] = duty_reg.duty_u > duty_reg.duty_v;
        idx[1] = duty_reg.duty_w > duty_reg.duty_u;
        idx[0] = duty_reg.duty_v > duty_reg.duty_w;
        entry_next = sect_lookup(idx);
    end

    logic                  v2_reg;
    logic [2:0][CMP_W-1:0] cmp_reg;
    sect_entry_t           entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            cmp_reg   <= cmp_next;
            entry_reg <= entry_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: limit near the period, then shift max/min edges apart
    // ------------------------------------------------------------------
    cmp_t    gap16;
    cmp_t    lim;
    cmp_t    c_mx;
    cmp_t    c_md;
    cmp_t    c_mn;
    cmp_t    comp_mx;
    cmp_t    comp_md;
    cmp_t    dmax;
    cmp_t    dmin;
    cmp_t    s_mx;
    cmp_t    s_mn;
    cmp_t    rise_mx;
    cmp_t    fall_mx;
    cmp_t    rise_mn;
    cmp_t    fall_mn;
    logic    active;
    logic [2:0][CMP_W-1:0] rise_ph;
    logic [2:0][CMP_W-1:0] fall_ph;
    result_t result_next;

    always_comb
    begin
        gap16  = CMP_W'(min_gap_reg);
        lim    = period_reg - gap16;
        active = (entry_reg.sector != SECTOR_ZERO_LO) && (entry_reg.sector != SECTOR_ZERO_HI);

        c_mx = phase_pick(cmp_reg[0], cmp_reg[1], cmp_reg[2], entry_reg.mx);
        c_md = phase_pick(cmp_reg[0], cmp_reg[1], cmp_reg[2], entry_reg.md);
        c_mn = phase_pick(cmp_reg[0], cmp_reg[1], cmp_reg[2], entry_reg.mn);

        // max above limit pulls both max and medium in; else clamp medium only if it is above limit
        if (c_mx > lim)
        begin
            comp_mx = period_reg - {gap16[CMP_W-2:0], 1'b0};
            comp_md = lim;
        end
        else if (c_md > lim)
        begin
            comp_mx = c_mx;
            comp_md = lim;
        end
        else
        begin
            comp_mx = c_mx;
            comp_md = c_md;
        end

        dmax = comp_md - comp_mx;
        dmin = c_mn - comp_md;
        s_mx = gap16 - dmax;
        s_mn = gap16 - dmin;

        if (dmax < gap16)
        begin
            rise_mx = comp_mx - s_mx;
            fall_mx = comp_mx + s_mx;
        end
        else
        begin
            rise_mx = comp_mx;
            fall_mx = comp_mx;
        end

        if (dmin < gap16)
        begin
            rise_mn = c_mn + s_mn;
            fall_mn = c_mn - s_mn;
        end
        else
        begin
            rise_mn = c_mn;
            fall_mn = c_mn;
        end

        // route roles back onto phases; zero-vector sectors pass through
        for (int p = 0; p < 3; p++)
        begin
            if (!active)
            begin
                rise_ph[p] = cmp_reg[p];
                fall_ph[p] = cmp_reg[p];
            end
            else if (entry_reg.mx == phase_t'(p))
            begin
                rise_ph[p] = rise_mx;
                fall_ph[p] = fall_mx;
            end
            else if (entry_reg.md == phase_t'(p))
            begin
                rise_ph[p] = comp_md;
                fall_ph[p] = comp_md;
            end
            else
            begin
                rise_ph[p] = rise_mn;
                fall_ph[p] = fall_mn;
            end
        end

        result_next.rise_u = rise_ph[0];
        result_next.rise_v = rise_ph[1];
        result_next.rise_w = rise_ph[2];
        result_next.fall_u = fall_ph[0];
        result_next.fall_v = fall_ph[1];
        result_next.fall_w = fall_ph[2];
        result_next.sector = entry_reg.sector;
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
